// ===== src/mbe_pkg.sv =====
// shared constants, types and fixed-point helpers for the escape-time block
package mbe_pkg;

    // number format and sizes
    localparam int FRAC_BITS  = 28;
    localparam int VAL_BITS   = FRAC_BITS + 4;
    localparam int PROD_W     = 2 * VAL_BITS;
    localparam int MAX_SIDE   = 4096;
    localparam int PIX_W      = 12;
    localparam int SIDE_W     = PIX_W + 1;
    localparam int DIFF_W     = PIX_W + 3;
    localparam int ITER_W     = 16;
    localparam int STEP_W     = 31;
    localparam int CTR_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // saturation limits
    localparam logic signed [VAL_BITS-1:0] VAL_MAX = {1'b0, {(VAL_BITS-1){1'b1}}};
    localparam logic signed [VAL_BITS-1:0] VAL_MIN = {1'b1, {(VAL_BITS-1){1'b0}}};
    localparam logic signed [PROD_W-1:0] PROD_MAX =
        {{(PROD_W-VAL_BITS+1){1'b0}}, {(VAL_BITS-1){1'b1}}};
    localparam logic signed [PROD_W-1:0] PROD_MIN = ~PROD_MAX;
    localparam logic signed [PROD_W-1:0] FRAC_RND =
        {{(PROD_W-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};

    // escape radius squared, 4.0 in the value format
    localparam logic [VAL_BITS:0] ESC_LIMIT = (VAL_BITS+1)'(4) << FRAC_BITS;

    // register reset values
    localparam logic [ITER_W-1:0]       RST_MAX_ITER  = 16'd256;
    localparam logic [STEP_W-1:0]       RST_STEP      = 31'd1048576;
    localparam logic signed [CTR_W-1:0] RST_CENTER_RE = -32'sd134217728;
    localparam logic signed [CTR_W-1:0] RST_CENTER_IM = 32'sd0;
    localparam logic [SIDE_W-1:0]       RST_WIDTH     = 13'd1024;
    localparam logic [SIDE_W-1:0]       RST_HEIGHT    = 13'd768;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_ITER  = 3'd0,
        CFG_STEP      = 3'd1,
        CFG_CENTER_RE = 3'd2,
        CFG_CENTER_IM = 3'd3,
        CFG_WIDTH     = 3'd4,
        CFG_HEIGHT    = 3'd5
    } t_cfg_idx;

    // register contents seen by the core
    typedef struct packed {
        logic [ITER_W-1:0]       max_iter;
        logic [STEP_W-1:0]       step;
        logic signed [CTR_W-1:0] center_re;
        logic signed [CTR_W-1:0] center_im;
        logic [SIDE_W-1:0]       width;
        logic [SIDE_W-1:0]       height;
    } t_cfg;

    // clamp a wide signed value into the value range
    function automatic logic signed [VAL_BITS-1:0] f_clamp(
        input logic signed [PROD_W-1:0] a
    );
        if (a > PROD_MAX) begin
            f_clamp = VAL_MAX;
        end else if (a < PROD_MIN) begin
            f_clamp = VAL_MIN;
        end else begin
            f_clamp = a[VAL_BITS-1:0];
        end
    endfunction

    // saturating add of two values
    function automatic logic signed [VAL_BITS-1:0] f_sadd(
        input logic signed [VAL_BITS-1:0] a,
        input logic signed [VAL_BITS-1:0] b
    );
        logic [VAL_BITS:0] s;
        s = {a[VAL_BITS-1], a} + {b[VAL_BITS-1], b};
        if (s[VAL_BITS] != s[VAL_BITS-1]) begin
            f_sadd = s[VAL_BITS] ? VAL_MIN : VAL_MAX;
        end else begin
            f_sadd = s[VAL_BITS-1:0];
        end
    endfunction

    // product back to value format, truncated toward zero, saturated
    function automatic logic signed [VAL_BITS-1:0] f_fix(
        input logic signed [PROD_W-1:0] a
    );
        logic signed [PROD_W-1:0] t;
        t = a + (a[PROD_W-1] ? FRAC_RND : {PROD_W{1'b0}});
        t = t >>> FRAC_BITS;
        f_fix = f_clamp(t);
    endfunction

    // halve toward zero, saturated
    function automatic logic signed [VAL_BITS-1:0] f_half(
        input logic signed [PROD_W-1:0] a
    );
        logic signed [PROD_W-1:0] t;
        t = a + (a[PROD_W-1] ? PROD_W'(1) : {PROD_W{1'b0}});
        t = t >>> 1;
        f_half = f_clamp(t);
    endfunction

endpackage

// ===== src/mbe_mul.sv =====
// shared signed multiplier with registered product
module mbe_mul
    import mbe_pkg::*;
(
    input  logic                       i_clk,
    input  logic signed [VAL_BITS-1:0] i_a,
    input  logic signed [VAL_BITS-1:0] i_b,
    output logic signed [PROD_W-1:0]   o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    // full-width product, one per cycle
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

// ===== src/mbe_cfg.sv =====
// configuration register file
module mbe_cfg
    import mbe_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // writes are always taken outside reset
    assign o_cfg_ready = i_rst_n;

    // register update on a write request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_iter  <= RST_MAX_ITER;
            r_cfg.step      <= RST_STEP;
            r_cfg.center_re <= RST_CENTER_RE;
            r_cfg.center_im <= RST_CENTER_IM;
            r_cfg.width     <= RST_WIDTH;
            r_cfg.height    <= RST_HEIGHT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MAX_ITER:  r_cfg.max_iter  <= i_cfg_data[ITER_W-1:0];
                CFG_STEP:      r_cfg.step      <= i_cfg_data[STEP_W-1:0];
                CFG_CENTER_RE: r_cfg.center_re <= i_cfg_data[CTR_W-1:0];
                CFG_CENTER_IM: r_cfg.center_im <= i_cfg_data[CTR_W-1:0];
                CFG_WIDTH:     r_cfg.width     <= i_cfg_data[SIDE_W-1:0];
                CFG_HEIGHT:    r_cfg.height    <= i_cfg_data[SIDE_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/mbe_core.sv =====
// sequencer and datapath around the shared multiplier
module mbe_core
    import mbe_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [PIX_W-1:0]  i_pixel_x,
    input  logic [PIX_W-1:0]  i_pixel_y,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [ITER_W-1:0] o_iteration_count
);

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_CX   = 11'b000_0000_0010,
        S_CY   = 11'b000_0000_0100,
        S_OY   = 11'b000_0000_1000,
        S_CC   = 11'b000_0001_0000,
        S_RI   = 11'b000_0010_0000,
        S_RR   = 11'b000_0100_0000,
        S_II   = 11'b000_1000_0000,
        S_SQ   = 11'b001_0000_0000,
        S_UPD  = 11'b010_0000_0000,
        S_DONE = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    logic [PIX_W-1:0]           r_px, r_py;
    logic signed [VAL_BITS-1:0] r_off, r_cr, r_ci, r_zr, r_zi, r_p, r_r2, r_i2;
    logic [ITER_W-1:0]          r_count, r_out_count;

    logic [SIDE_W-1:0]          side_x, side_y;
    logic signed [DIFF_W-1:0]   d_x, d_y;
    logic signed [VAL_BITS-1:0] mul_a, mul_b, fix_q, half_q, cen_re, cen_im, step_v;
    logic signed [PROD_W-1:0]   prod;
    logic [VAL_BITS:0]          mag_sum;
    logic                       escape;
    logic [ITER_W-1:0]          count_inc;
    logic                       out_load, out_take;

    // pixel offset from the image middle, doubled so that half a side stays exact
    assign side_x = (i_cfg.width  > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : i_cfg.width;
    assign side_y = (i_cfg.height > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : i_cfg.height;
    assign d_x = $signed({2'b00, r_px, 1'b0}) - $signed({2'b00, side_x});
    assign d_y = $signed({2'b00, r_py, 1'b0}) - $signed({2'b00, side_y});
    assign step_v = $signed(VAL_BITS'({1'b0, i_cfg.step}));
    assign cen_re = f_clamp(PROD_W'(i_cfg.center_re));
    assign cen_im = f_clamp(PROD_W'(i_cfg.center_im));

    // operand selection for the shared multiplier
    always_comb begin
        case (r_state)
            S_CX: begin
                mul_a = {{(VAL_BITS-DIFF_W){d_x[DIFF_W-1]}}, d_x};
                mul_b = step_v;
            end
            S_CY: begin
                mul_a = {{(VAL_BITS-DIFF_W){d_y[DIFF_W-1]}}, d_y};
                mul_b = step_v;
            end
            S_RR: begin
                mul_a = r_zr;
                mul_b = r_zr;
            end
            S_II: begin
                mul_a = r_zi;
                mul_b = r_zi;
            end
            default: begin
                mul_a = r_zr;
                mul_b = r_zi;
            end
        endcase
    end

    mbe_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // product post-processing and escape test
    assign fix_q     = f_fix(prod);
    assign half_q    = f_half(prod);
    assign mag_sum   = {1'b0, r_r2} + {1'b0, r_i2};
    assign escape    = (mag_sum >= ESC_LIMIT);
    assign count_inc = r_count + 1'b1;

    // result register handshake
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    assign out_take    = r_out_valid && !i_out_stall;
    assign n_out_valid = out_load || (r_out_valid && !out_take);

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_CX;
            S_CX:   n_state = S_CY;
            S_CY:   n_state = S_OY;
            S_OY:   n_state = S_CC;
            S_CC:   n_state = (i_cfg.max_iter == '0) ? S_DONE : S_RI;
            S_RI:   n_state = S_RR;
            S_RR:   n_state = S_II;
            S_II:   n_state = S_SQ;
            S_SQ:   n_state = S_UPD;
            S_UPD: begin
                if (escape || (count_inc == i_cfg.max_iter)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_RI;
                end
            end
            S_DONE: if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    r_px <= i_pixel_x;
                    r_py <= i_pixel_y;
                end
            end
            S_CY: r_off <= half_q;
            S_OY: begin
                r_cr  <= f_sadd(cen_re, r_off);
                r_zr  <= f_sadd(cen_re, r_off);
                r_off <= half_q;
            end
            S_CC: begin
                r_ci    <= f_sadd(cen_im, r_off);
                r_zi    <= f_sadd(cen_im, r_off);
                r_count <= '0;
            end
            S_RR: r_p  <= fix_q;
            S_II: r_r2 <= fix_q;
            S_SQ: r_i2 <= fix_q;
            S_UPD: begin
                // z = z^2 + c for an orbit still inside the radius
                if (!escape) begin
                    r_count <= count_inc;
                    r_zr    <= f_sadd(r_r2 - r_i2, r_cr);
                    r_zi    <= f_sadd(f_sadd(r_p, r_p), r_ci);
                end
            end
            S_DONE: if (out_load) r_out_count <= r_count;
            default: ;
        endcase
    end

    assign o_in_stall        = !i_rst_n || (r_state != S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_iteration_count = r_out_count;

endmodule

// ===== src/mandelbrot_escape_time.sv =====
// top level of the escape-time counter
//
// Channels: pixel requests (i_in_valid / o_in_stall with i_pixel_x, i_pixel_y),
// results (o_out_valid / i_out_stall with o_iteration_count) and a register
// write port (i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data).
// One pixel request is worked on at a time. Its point c is formed first with
// two passes through the shared 32x32 multiplier, then every orbit step uses
// that multiplier three times (zr*zi, zr^2, zi^2). The next request is taken
// only once the result of the last one has been loaded into the output register.
// The result sits in an output register; while the receiver stalls it holds
// there and a finished pixel waits in its last state until the register frees.
// Synchronous reset restores the register defaults, drops any pending result
// and holds the request and write ports off for its duration.
module mandelbrot_escape_time
    import mbe_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [PIX_W-1:0]      i_pixel_x,
    input  logic [PIX_W-1:0]      i_pixel_y,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [ITER_W-1:0]     o_iteration_count
);

    t_cfg cfg;

    // register file
    mbe_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // iteration engine
    mbe_core u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (cfg),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_pixel_x         (i_pixel_x),
        .i_pixel_y         (i_pixel_y),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_iteration_count (o_iteration_count)
    );

endmodule

// ===== src/mbe_chk.sv =====
// port-level checks for the escape-time counter, bound to the top level
module mbe_chk
    import mbe_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input logic [ITER_W-1:0]     o_iteration_count
);

    // reset drops any pending result
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result still valid after reset");

    // a taken request keeps the block busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request port open right after a request");

    // stalled result holds
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_iteration_count))
        else $error("stalled result changed");

    // a new result only comes out of work in progress
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared while idle");

endmodule

bind mandelbrot_escape_time mbe_chk u_chk (.*);
